FILE: design/view_cone_angle_test_macros.svh
// ----------------------------------------------------------------------------
// view_cone_angle_test_macros
// Assertion macros shared by the view cone RTL.
// ----------------------------------------------------------------------------
`ifndef VIEW_CONE_ANGLE_TEST_MACROS_SVH
`define VIEW_CONE_ANGLE_TEST_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define VCAT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("view cone assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define VCAT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("view cone assertion failed");

`endif

FILE: design/vcat_pkg.sv
// ----------------------------------------------------------------------------
// vcat_pkg
// Types, constants and the arctangent table of the view cone test.
// ----------------------------------------------------------------------------
package vcat_pkg;

  // CORDIC datapath widths
  localparam int unsigned DataW = 38;  // x/y of the vectoring CORDIC
  localparam int unsigned AngW  = 28;  // angle accumulator, Q.24 rad
  localparam int unsigned TabLen = 24;

  // Angle constants
  localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic [19:0]            KinvQ20   = 20'd636751;
  localparam logic signed [18:0]     PiQ13     = 19'sd25736;
  localparam logic signed [18:0]     TwoPiQ13  = 19'sd51472;

  typedef enum logic [1:0] {
    VERD_INSIDE = 2'd0,
    VERD_YAW    = 2'd1,
    VERD_PITCH  = 2'd2
  } verdict_e;

  // atan(2^-i) in Q.24
  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/vcat_in_if.sv
// ----------------------------------------------------------------------------
// vcat_in_if
// Query channel: signal and sensor positions plus sensor orientation.
// ----------------------------------------------------------------------------
interface vcat_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] signal_x;
  logic signed [31:0] signal_y;
  logic signed [31:0] signal_z;
  logic signed [31:0] sensor_x;
  logic signed [31:0] sensor_y;
  logic signed [31:0] sensor_z;
  logic signed [15:0] sensor_pitch;
  logic signed [15:0] sensor_yaw;

  modport source (
    output valid, signal_x, signal_y, signal_z, sensor_x, sensor_y, sensor_z,
           sensor_pitch, sensor_yaw,
    input  ready
  );
  modport sink (
    input  valid, signal_x, signal_y, signal_z, sensor_x, sensor_y, sensor_z,
           sensor_pitch, sensor_yaw,
    output ready
  );
endinterface

FILE: design/vcat_out_if.sv
// ----------------------------------------------------------------------------
// vcat_out_if
// Result channel: visibility flag and verdict code.
// ----------------------------------------------------------------------------
interface vcat_out_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic [1:0] verdict;

  modport source (output valid, visible, verdict, input ready);
  modport sink   (input valid, visible, verdict, output ready);
endinterface

FILE: design/vcat_cordic.sv
// ----------------------------------------------------------------------------
// vcat_cordic
// Pipelined vectoring CORDIC, one iteration per register stage, with a
// sideband word that travels alongside. Each stage holds its own valid bit
// and loads whenever it is empty or the stage after it moves.
// ----------------------------------------------------------------------------
module vcat_cordic import vcat_pkg::*; #(
  parameter int unsigned ITER = 16,
  parameter int unsigned SW   = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [DataW-1:0] x_i,
  input  logic signed [DataW-1:0] y_i,
  input  logic signed [AngW-1:0]  z_i,
  input  logic [SW-1:0]          side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [DataW-1:0] x_o,
  output logic signed [AngW-1:0]  z_o,
  output logic [SW-1:0]          side_o
);

  logic signed [DataW-1:0] x_q [ITER];
  logic signed [DataW-1:0] y_q [ITER];
  logic signed [AngW-1:0]  z_q [ITER];
  logic [SW-1:0]           s_q [ITER];
  logic [ITER-1:0]         v_q;
  logic [ITER:0]           rdy;

  assign rdy[ITER] = out_ready_i;

  for (genvar gi = 0; gi < ITER; gi++) begin : g_stg
    logic signed [DataW-1:0] x_in, y_in, xs, ys, x_d, y_d;
    logic signed [AngW-1:0]  z_in, z_d;
    logic [SW-1:0]           s_in;
    logic                    v_in;

    if (gi == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
      assign s_in = side_i;
      assign v_in = in_valid_i;
    end else begin : g_next
      assign x_in = x_q[gi-1];
      assign y_in = y_q[gi-1];
      assign z_in = z_q[gi-1];
      assign s_in = s_q[gi-1];
      assign v_in = v_q[gi-1];
    end

    assign rdy[gi] = !v_q[gi] || rdy[gi+1];

    // One micro-rotation toward y = 0
    always_comb begin
      xs = x_in >>> gi;
      ys = y_in >>> gi;
      if (y_in > 0) begin
        x_d = x_in + ys;
        y_d = y_in - xs;
        z_d = z_in + atan_q24(5'(gi));
      end else begin
        x_d = x_in - ys;
        y_d = y_in + xs;
        z_d = z_in - atan_q24(5'(gi));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi] <= 1'b0;
      end else if (rdy[gi]) begin
        v_q[gi] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[gi] && v_in) begin
        x_q[gi] <= x_d;
        y_q[gi] <= y_d;
        z_q[gi] <= z_d;
        s_q[gi] <= s_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[ITER-1];
  assign x_o         = x_q[ITER-1];
  assign z_o         = z_q[ITER-1];
  assign side_o      = s_q[ITER-1];

endmodule

FILE: design/view_cone_angle_test.sv
// ----------------------------------------------------------------------------
// view_cone_angle_test
// Field-of-view cone test: yaw and pitch of the direction to a signal,
// compared against the sensor orientation and a programmable half angle.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake         Contents
//  in_i      in    valid/ready       signal xyz, sensor xyz, pitch, yaw
//  out_o     out   valid/ready       visible, verdict
//  cfg       in    cfg_we_i (write)  cone half angle, Q2.13 rad
//
//  One query per cycle while the output is not stalled; 2*ITER+4 register
//  stages (ITER = CORDIC_ITERATIONS, at most 24): stage A, the yaw CORDIC
//  of ITER stages, stages B and C, the pitch CORDIC of ITER stages, stage D.
//  Every stage has its own valid bit and fills when the stage after it moves,
//  so a stalled output lets earlier stages keep taking queries until full.
//  Asynchronous active-low reset empties the pipeline and sets the half
//  angle to 4288 (about 30 degrees).
// ----------------------------------------------------------------------------
`include "view_cone_angle_test_macros.svh"

module view_cone_angle_test import vcat_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vcat_in_if.sink     in_i,
  vcat_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);

  localparam int unsigned ITER = (CORDIC_ITERATIONS > TabLen) ? TabLen : CORDIC_ITERATIONS;

  typedef struct packed {
    logic signed [32:0] dy;
    logic signed [15:0] spitch;
    logic signed [15:0] syaw;
    logic               hz;
  } yaw_side_t;

  typedef struct packed {
    logic signed [15:0] spitch;
    logic               yaw_ok;
    logic               pz;
  } pitch_side_t;

  // Half-angle register
  logic [14:0] cone_half_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_half_q <= 15'd4288;
    end else if (cfg_we_i) begin
      cone_half_q <= cfg_wdata_i;
    end
  end

  // Stage A: direction vector and pre-rotation into the right half plane
  logic signed [32:0]      dx, dy, dz;
  logic signed [DataW-1:0] xa_d, ya_d;
  logic signed [AngW-1:0]  za_d;
  logic signed [DataW-1:0] xa_q, ya_q;
  logic signed [AngW-1:0]  za_q;
  yaw_side_t               sa_d, sa_q;
  logic                    va_q, rdy_a, c1_in_ready;

  always_comb begin
    dx = {in_i.signal_x[31], in_i.signal_x} - {in_i.sensor_x[31], in_i.sensor_x};
    dy = {in_i.signal_y[31], in_i.signal_y} - {in_i.sensor_y[31], in_i.sensor_y};
    dz = {in_i.signal_z[31], in_i.signal_z} - {in_i.sensor_z[31], in_i.sensor_z};
    xa_d = DataW'(dz);
    ya_d = DataW'(dx);
    za_d = '0;
    if (dz < 0) begin
      if (dx >= 0) begin
        xa_d = DataW'(dx);
        ya_d = -DataW'(dz);
        za_d = HalfPiQ24;
      end else begin
        xa_d = -DataW'(dx);
        ya_d = DataW'(dz);
        za_d = -HalfPiQ24;
      end
    end
    sa_d.dy     = dy;
    sa_d.spitch = in_i.sensor_pitch;
    sa_d.syaw   = in_i.sensor_yaw;
    sa_d.hz     = (dx == '0) && (dz == '0);
  end

  assign rdy_a      = !va_q || c1_in_ready;
  assign in_i.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_i.valid) begin
      xa_q <= xa_d;
      ya_q <= ya_d;
      za_q <= za_d;
      sa_q <= sa_d;
    end
  end

  // Yaw CORDIC
  logic                    c1_out_valid, rdy_b;
  logic signed [DataW-1:0] c1_mag;
  logic signed [AngW-1:0]  c1_ang;
  logic [$bits(yaw_side_t)-1:0] c1_side;
  yaw_side_t               sb_in;

  vcat_cordic #(.ITER(ITER), .SW($bits(yaw_side_t))) u_yaw_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (va_q),
    .in_ready_o (c1_in_ready),
    .x_i        (xa_q),
    .y_i        (ya_q),
    .z_i        (za_q),
    .side_i     (sa_q),
    .out_valid_o(c1_out_valid),
    .out_ready_i(rdy_b),
    .x_o        (c1_mag),
    .z_o        (c1_ang),
    .side_o     (c1_side)
  );
  assign sb_in = yaw_side_t'(c1_side);

  // Stage B: gain removal and yaw rounding to Q3.13
  logic [DataW+19:0]       prod;
  logic signed [AngW-1:0]  yaw_sum;
  logic signed [DataW-1:0] hb_d, hb_q;
  logic signed [16:0]      yawb_d, yawb_q;
  logic signed [32:0]      dyb_q;
  logic signed [15:0]      spb_q, syb_q;
  logic                    vb_q, rdy_c;

  always_comb begin
    prod    = (DataW+20)'($unsigned(c1_mag)) * (DataW+20)'(KinvQ20);
    yaw_sum = c1_ang + AngW'(1024);
    hb_d    = sb_in.hz ? '0 : DataW'(prod[DataW+19:20]);
    yawb_d  = sb_in.hz ? '0 : yaw_sum[AngW-1:11];
  end

  assign rdy_b = !vb_q || rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= c1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && c1_out_valid) begin
      hb_q   <= hb_d;
      yawb_q <= yawb_d;
      dyb_q  <= sb_in.dy;
      spb_q  <= sb_in.spitch;
      syb_q  <= sb_in.syaw;
    end
  end

  // Stage C: wrapped yaw offset test, pitch CORDIC setup
  logic signed [18:0]      yoff, yoff_w, yoff_abs;
  logic signed [DataW-1:0] hc_q, dyc_q;
  pitch_side_t             sc_d, sc_q;
  logic                    vc_q, c2_in_ready;

  always_comb begin
    yoff = 19'(yawb_q) - 19'(syb_q);
    if (yoff > PiQ13) begin
      yoff_w = yoff - TwoPiQ13;
    end else if (yoff < -PiQ13) begin
      yoff_w = yoff + TwoPiQ13;
    end else begin
      yoff_w = yoff;
    end
    yoff_abs    = (yoff_w < 0) ? -yoff_w : yoff_w;
    sc_d.spitch = spb_q;
    sc_d.yaw_ok = yoff_abs < $signed({4'b0, cone_half_q});
    sc_d.pz     = (hb_q == '0) && (dyb_q == '0);
  end

  assign rdy_c = !vc_q || c2_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      hc_q  <= hb_q;
      dyc_q <= DataW'(dyb_q);
      sc_q  <= sc_d;
    end
  end

  // Pitch CORDIC
  logic                    c2_out_valid, rdy_d;
  logic signed [DataW-1:0] c2_mag;
  logic signed [AngW-1:0]  c2_ang;
  logic [$bits(pitch_side_t)-1:0] c2_side;
  pitch_side_t             sd_in;

  vcat_cordic #(.ITER(ITER), .SW($bits(pitch_side_t))) u_pitch_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vc_q),
    .in_ready_o (c2_in_ready),
    .x_i        (hc_q),
    .y_i        (dyc_q),
    .z_i        ('0),
    .side_i     (sc_q),
    .out_valid_o(c2_out_valid),
    .out_ready_i(rdy_d),
    .x_o        (c2_mag),
    .z_o        (c2_ang),
    .side_o     (c2_side)
  );
  assign sd_in = pitch_side_t'(c2_side);

  // Stage D: pitch offset test and verdict, output register
  logic signed [AngW-1:0] pitch_sum;
  logic signed [16:0]     pitch;
  logic signed [17:0]     poff, poff_abs;
  logic                   pitch_ok;
  verdict_e               verdict_d, verdict_q;
  logic                   vd_q;

  always_comb begin
    pitch_sum = c2_ang + AngW'(1024);
    pitch     = sd_in.pz ? '0 : pitch_sum[AngW-1:11];
    poff      = 18'(pitch) + 18'(sd_in.spitch);
    poff_abs  = (poff < 0) ? -poff : poff;
    pitch_ok  = poff_abs < $signed({3'b0, cone_half_q});
    if (!sd_in.yaw_ok) begin
      verdict_d = VERD_YAW;
    end else if (!pitch_ok) begin
      verdict_d = VERD_PITCH;
    end else begin
      verdict_d = VERD_INSIDE;
    end
  end

  assign rdy_d = !vd_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (rdy_d) begin
      vd_q <= c2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && c2_out_valid) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_o.valid   = vd_q;
  assign out_o.verdict = verdict_q;
  assign out_o.visible = (verdict_q == VERD_INSIDE);

  // magnitude output of the pitch unit is not needed
  logic unused_mag;
  assign unused_mag = ^c2_mag;

  // Checks
  `VCAT_ASSERT_IMP(a_ready_only_when_backed_up, !in_i.ready, vd_q && !out_o.ready)
  `VCAT_ASSERT_IMP(a_verdict_code_legal, vd_q, verdict_q <= VERD_PITCH)
  `VCAT_ASSERT_NXT(a_cfg_write_lands, cfg_we_i, cone_half_q == $past(cfg_wdata_i))

endmodule
